/* src/qte_pkg.sv */
// Shared constants, types and the arctangent table for the quaternion to Euler block.
// No dependencies; used by every module in src.
package qte_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned TabLen          = 24;
  localparam int unsigned CW              = 36;  // CORDIC vector width
  localparam int unsigned AW              = 34;  // binary angle width
  localparam int unsigned SqrtSteps       = 31;  // one result bit per step
  localparam int unsigned NW              = 61;  // square root radicand width
  localparam int unsigned RW              = 62;  // square root work register width

  localparam logic [30:0] ThrReset = 31'd536869838;
  localparam logic [31:0] PiQ29    = 32'd1686629713;
  localparam int          HeadMax  = 25736;
  localparam int          AttMax   = 6434;
  localparam int          BankMax  = 12868;

  typedef enum logic [1:0] {
    LockNone  = 2'd0,
    LockNorth = 2'd1,
    LockSouth = 2'd2
  } lock_e;

  typedef struct packed {
    lock_e                 lock;
    logic signed [CW-1:0]  hy;
    logic signed [CW-1:0]  hx;
    logic signed [CW-1:0]  by;
    logic signed [CW-1:0]  bx;
    logic signed [CW-1:0]  sy;
  } side_t;

  // atan(2^-i), 2^32 is one full turn
  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* src/qte_front.sv */
// Front end: component products, singularity test, lock decision and CORDIC operands.
// Three register stages; depends on qte_pkg.
module qte_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [15:0]   quat_w_i,
  input  logic signed [15:0]   quat_x_i,
  input  logic signed [15:0]   quat_y_i,
  input  logic signed [15:0]   quat_z_i,
  input  logic [30:0]          thr_i,
  output logic                 valid_o,
  output logic [qte_pkg::NW-1:0] n_o,
  output qte_pkg::side_t       side_o
);
  import qte_pkg::*;

  localparam logic signed [CW-1:0] One = CW'(64'sd1073741824);
  localparam logic signed [33:0]   SLim = 34'sd1073741824;
  localparam logic signed [64:0]   Two60 = 65'sd1 <<< 60;

  // stage 1
  logic               v1_q;
  logic signed [31:0] xy_q, zw_q, yw_q, xz_q, xw_q, yz_q, xx_q, yy_q, zz_q;
  logic signed [15:0] x1_q, w1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xy_q <= quat_x_i * quat_y_i;
      zw_q <= quat_z_i * quat_w_i;
      yw_q <= quat_y_i * quat_w_i;
      xz_q <= quat_x_i * quat_z_i;
      xw_q <= quat_x_i * quat_w_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      x1_q <= quat_x_i;
      w1_q <= quat_w_i;
    end
  end

  // stage 2
  logic signed [32:0]   t_d;
  logic signed [32:0]   thr_s;
  logic signed [33:0]   t2_d;
  logic signed [31:0]   s_d;
  lock_e                lock_d;
  logic                 v2_q;
  lock_e                lock_q;
  logic signed [CW-1:0] hy_q, hx_q, by_q, bx_q;
  logic signed [31:0]   s_q;

  always_comb begin
    t_d   = 33'(xy_q) + 33'(zw_q);
    thr_s = $signed({2'b00, thr_i});
    t2_d  = 34'(t_d) <<< 1;
    if (t2_d > SLim) begin
      s_d = 32'(SLim);
    end else if (t2_d < -SLim) begin
      s_d = 32'(-SLim);
    end else begin
      s_d = 32'(t2_d);
    end
    if (t_d > thr_s) begin
      lock_d = LockNorth;
    end else if (t_d < -thr_s) begin
      lock_d = LockSouth;
    end else begin
      lock_d = LockNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lock_q <= lock_d;
      if (lock_d != LockNone) begin
        hy_q <= CW'(x1_q) <<< 15;
        hx_q <= CW'(w1_q) <<< 15;
      end else begin
        hy_q <= (CW'(yw_q) - CW'(xz_q)) <<< 1;
        hx_q <= One - ((CW'(yy_q) + CW'(zz_q)) <<< 1);
      end
      by_q <= (CW'(xw_q) - CW'(yz_q)) <<< 1;
      bx_q <= One - ((CW'(xx_q) + CW'(zz_q)) <<< 1);
      s_q  <= s_d;
    end
  end

  // stage 3: radicand of the asin cosine
  logic signed [63:0] sq_d;
  logic               v3_q;

  assign sq_d = s_q * s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o         <= NW'(Two60 - 65'(sq_d));
      side_o.lock <= lock_q;
      side_o.hy   <= hy_q;
      side_o.hx   <= hx_q;
      side_o.by   <= by_q;
      side_o.bx   <= bx_q;
      side_o.sy   <= CW'(s_q);
    end
  end

  assign valid_o = v3_q;

endmodule

/* src/qte_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Carries the operand sideband alongside; depends on qte_pkg.
module qte_sqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [qte_pkg::NW-1:0] n_i,
  input  qte_pkg::side_t         side_i,
  output logic                   valid_o,
  output logic [30:0]            root_o,
  output qte_pkg::side_t         side_o
);
  import qte_pkg::*;

  logic [NW-1:0] n_q    [SqrtSteps+1];
  logic [RW-1:0] root_q [SqrtSteps+1];
  logic          v_q    [SqrtSteps+1];
  side_t         side_q [SqrtSteps+1];

  assign n_q[0]    = n_i;
  assign root_q[0] = '0;
  assign v_q[0]    = valid_i;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [RW-1:0] Bit = RW'(1) << (2 * (SqrtSteps - 1 - k));
    logic [RW-1:0] trial;
    assign trial = root_q[k] + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= side_q[k];
        if (RW'(n_q[k]) >= trial) begin
          n_q[k+1]    <= NW'(RW'(n_q[k]) - trial);
          root_q[k+1] <= (root_q[k] >> 1) + Bit;
        end else begin
          n_q[k+1]    <= n_q[k];
          root_q[k+1] <= root_q[k] >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[SqrtSteps];
  assign root_o  = root_q[SqrtSteps][30:0];
  assign side_o  = side_q[SqrtSteps];

endmodule

/* src/qte_cordic.sv */
// Pipelined vectoring CORDIC atan2 with binary angle output (2^32 is one turn).
// One pre-rotation stage plus one stage per iteration; depends on qte_pkg.
module qte_cordic #(
  parameter int unsigned STAGES = qte_pkg::CordicStagesDef,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [qte_pkg::CW-1:0] y_i,
  input  logic signed [qte_pkg::CW-1:0] x_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         valid_o,
  output logic signed [qte_pkg::AW-1:0] ang_o,
  output logic [SIDE_W-1:0]            side_o
);
  import qte_pkg::*;

  localparam logic signed [AW-1:0] HalfTurn = AW'(64'sd2147483648);

  logic signed [CW-1:0] x_q   [STAGES+1];
  logic signed [CW-1:0] y_q   [STAGES+1];
  logic signed [AW-1:0] ang_q [STAGES+1];
  logic                 z_q   [STAGES+1];
  logic                 v_q   [STAGES+1];
  logic [SIDE_W-1:0]    sd_q  [STAGES+1];

  // pre-rotation: move the vector into the right half plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]  <= (x_i == '0) && (y_i == '0);
      sd_q[0] <= side_i;
      if (x_i < 0) begin
        x_q[0]   <= -x_i;
        y_q[0]   <= -y_i;
        ang_q[0] <= (y_i >= 0) ? HalfTurn : -HalfTurn;
      end else begin
        x_q[0]   <= x_i;
        y_q[0]   <= y_i;
        ang_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [AW-1:0] TabVal = AW'(atan_tab(5'(i)));
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1]  <= z_q[i];
        sd_q[i+1] <= sd_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1]   <= x_q[i] + ys;
          y_q[i+1]   <= y_q[i] - xs;
          ang_q[i+1] <= ang_q[i] + TabVal;
        end else begin
          x_q[i+1]   <= x_q[i] - ys;
          y_q[i+1]   <= y_q[i] + xs;
          ang_q[i+1] <= ang_q[i] - TabVal;
        end
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign ang_o   = z_q[STAGES] ? '0 : ang_q[STAGES];
  assign side_o  = sd_q[STAGES];

endmodule

/* src/qte_scale.sv */
// Binary angle to Q3.12/Q1.12/Q2.12 radians, lock case overrides, saturation.
// Two register stages, the second is the output register; depends on qte_pkg.
module qte_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  qte_pkg::lock_e                lock_i,
  input  logic signed [qte_pkg::AW-1:0] head_i,
  input  logic signed [qte_pkg::AW-1:0] att_i,
  input  logic signed [qte_pkg::AW-1:0] bank_i,
  output logic                          valid_o,
  output logic signed [15:0]            heading_o,
  output logic signed [13:0]            attitude_o,
  output logic signed [14:0]            bank_o,
  output qte_pkg::lock_e                lock_o
);
  import qte_pkg::*;

  localparam int unsigned HW = AW - 16;
  localparam int unsigned PW = HW + 32;
  localparam logic signed [32:0] Pi = $signed({1'b0, PiQ29});
  localparam logic signed [65:0] Half = 66'sd1 <<< 47;
  localparam logic signed [19:0] HeadLim = 20'(HeadMax);
  localparam logic signed [19:0] AttLim  = 20'(AttMax);
  localparam logic signed [19:0] BankLim = 20'(BankMax);

  function automatic logic signed [19:0] clip(input logic signed [19:0] v,
                                              input logic signed [19:0] lim);
    logic signed [19:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // stage 1: high signed and low unsigned half of each angle, times pi
  logic signed [PW-1:0] hh_q, ah_q, bh_q;
  logic [47:0]          hl_q, al_q, bl_q;
  lock_e                lock_q;
  logic                 v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q   <= PW'($signed(head_i[AW-1:16]) * Pi);
      ah_q   <= PW'($signed(att_i[AW-1:16]) * Pi);
      bh_q   <= PW'($signed(bank_i[AW-1:16]) * Pi);
      hl_q   <= 48'(head_i[15:0] * PiQ29);
      al_q   <= 48'(att_i[15:0] * PiQ29);
      bl_q   <= 48'(bank_i[15:0] * PiQ29);
      lock_q <= lock_i;
    end
  end

  // stage 2: round half up, apply lock overrides and saturate
  logic signed [65:0] hs, as_d, bs;
  logic signed [19:0] hq, aq, bq, h_d, a_d, b_d;

  always_comb begin
    hs   = (66'(hh_q) <<< 16) + $signed({18'b0, hl_q}) + Half;
    as_d = (66'(ah_q) <<< 16) + $signed({18'b0, al_q}) + Half;
    bs   = (66'(bh_q) <<< 16) + $signed({18'b0, bl_q}) + Half;
    hq   = 20'(hs >>> 48);
    aq   = 20'(as_d >>> 48);
    bq   = 20'(bs >>> 48);
    unique case (lock_q)
      LockNorth: begin
        h_d = clip(hq <<< 1, HeadLim);
        a_d = AttLim;
        b_d = '0;
      end
      LockSouth: begin
        h_d = clip(-(hq <<< 1), HeadLim);
        a_d = -AttLim;
        b_d = '0;
      end
      default: begin
        h_d = clip(hq, HeadLim);
        a_d = clip(aq, AttLim);
        b_d = clip(bq, BankLim);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      heading_o  <= h_d[15:0];
      attitude_o <= a_d[13:0];
      bank_o     <= b_d[14:0];
      lock_o     <= lock_q;
    end
  end

endmodule

/* src/quat_to_euler.sv */
// Quaternion to heading / attitude / bank, fully pipelined.
// Register stages: 3 front, 31 square root, 1 + CORDIC_STAGES CORDIC, 2 scaling.
// Throughput one quaternion per cycle; a stall on the output freezes every stage.
// Reset clears all valid bits and loads the default singularity threshold.
module quat_to_euler #(
  parameter int unsigned CORDIC_STAGES = qte_pkg::CordicStagesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // heading_angle, attitude_angle, bank_angle, zero pad
  output logic [1:0]  m_axis_tuser_o    // lock_case
);
  import qte_pkg::*;

  logic        thr_q;
  logic [30:0] thr_val_q;
  logic        en;

  // advance whenever the output register is empty or being drained
  assign en              = m_axis_tready_i | ~m_axis_tvalid_o;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_val_q <= ThrReset;
      thr_q     <= 1'b0;
    end else if (cfg_we_i) begin
      thr_val_q <= cfg_wdata_i;
      thr_q     <= 1'b1;
    end
  end

  logic          f_valid;
  logic [NW-1:0] f_n;
  side_t         f_side;

  qte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i & thr_q | s_axis_tvalid_i & ~thr_q),
    .quat_w_i (s_axis_tdata_i[15:0]),
    .quat_x_i (s_axis_tdata_i[31:16]),
    .quat_y_i (s_axis_tdata_i[47:32]),
    .quat_z_i (s_axis_tdata_i[63:48]),
    .thr_i    (thr_val_q),
    .valid_o  (f_valid),
    .n_o      (f_n),
    .side_o   (f_side)
  );

  logic        r_valid;
  logic [30:0] r_root;
  side_t       r_side;

  qte_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .n_i     (f_n),
    .side_i  (f_side),
    .valid_o (r_valid),
    .root_o  (r_root),
    .side_o  (r_side)
  );

  logic                 c_valid;
  logic [1:0]           c_lock;
  logic signed [AW-1:0] c_head, c_att, c_bank;

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(2)) u_cordic_head (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_valid),
    .y_i     (r_side.hy),
    .x_i     (r_side.hx),
    .side_i  (r_side.lock),
    .valid_o (c_valid),
    .ang_o   (c_head),
    .side_o  (c_lock)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_att (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_valid),
    .y_i     (r_side.sy),
    .x_i     (CW'(r_root)),
    .side_i  (1'b0),
    .valid_o (),
    .ang_o   (c_att),
    .side_o  ()
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_valid),
    .y_i     (r_side.by),
    .x_i     (r_side.bx),
    .side_i  (1'b0),
    .valid_o (),
    .ang_o   (c_bank),
    .side_o  ()
  );

  logic signed [15:0] o_head;
  logic signed [13:0] o_att;
  logic signed [14:0] o_bank;
  lock_e              o_lock;

  qte_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (c_valid),
    .lock_i     (lock_e'(c_lock)),
    .head_i     (c_head),
    .att_i      (c_att),
    .bank_i     (c_bank),
    .valid_o    (m_axis_tvalid_o),
    .heading_o  (o_head),
    .attitude_o (o_att),
    .bank_o     (o_bank),
    .lock_o     (o_lock)
  );

  assign m_axis_tdata_o = {3'b000, o_bank, o_att, o_head};
  assign m_axis_tuser_o = o_lock;

endmodule

/* sim/tb_quat_to_euler.sv */
// Self-checking testbench for quat_to_euler: directed table, then random quaternions.
// Holds its own bit-exact angle predictor; depends on qte_pkg and the RTL in src.
module tb_quat_to_euler;
  timeunit 1ns;
  timeprecision 1ps;
  import qte_pkg::*;

  localparam int unsigned Latency  = 37 + CordicStagesDef;
  localparam int unsigned Stall    = 5000;
  localparam longint      PiQ29L   = 64'd1686629713;
  localparam longint      OneQ30   = 64'd1073741824;
  localparam longint      HalfTurn = 64'd2147483648;

  localparam longint AtanTurn [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct {
    logic signed [15:0] head;
    logic signed [13:0] att;
    logic signed [14:0] bank;
    lock_e              lock;
  } euler_t;

  typedef struct {
    quat_t q;
    bit    pinned;   // lock case typed in
    lock_e lock;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  quat_to_euler dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  euler_t      angles_due[$];
  longint      lock_limit = ThrReset;
  int          errors = 0;
  int          idle_mode = 0;  // 0: receiver sparse, 1: sender sparse, 2: none
  int unsigned quiet = 0;

  // ---------------- predictor ----------------
  function automatic longint vec_angle(longint y, longint x);
    longint ang = 0;
    longint xs, ys;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicStagesDef && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; ang += AtanTurn[i];
      end else begin
        x -= ys; y += xs; ang -= AtanTurn[i];
      end
    end
    return ang;
  endfunction

  function automatic longint turn_to_rad(longint ang);
    return (ang * PiQ29L + (64'sd1 <<< 47)) >>> 48;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return (v > lim) ? lim : (v < -lim) ? -lim : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic euler_t quat_angles(quat_t q);
    euler_t r;
    longint w = q.w, x = q.x, y = q.y, z = q.z;
    longint t = x * y + z * w;
    longint hd, at, bk, s;
    longint unsigned c;
    if (t > lock_limit) begin
      r.lock = LockNorth;
      hd = 2 * turn_to_rad(vec_angle(x * 32768, w * 32768));
      at = AttMax;
      bk = 0;
    end else if (t < -lock_limit) begin
      r.lock = LockSouth;
      hd = -2 * turn_to_rad(vec_angle(x * 32768, w * 32768));
      at = -AttMax;
      bk = 0;
    end else begin
      r.lock = LockNone;
      s = clip(2 * t, OneQ30);
      c = int_sqrt((64'd1 << 60) - longint'(s * s));
      hd = turn_to_rad(vec_angle(2 * (y * w - x * z), OneQ30 - 2 * (y * y + z * z)));
      at = turn_to_rad(vec_angle(s, longint'(c)));
      bk = turn_to_rad(vec_angle(2 * (x * w - y * z), OneQ30 - 2 * (x * x + z * z)));
    end
    r.head = 16'(clip(hd, HeadMax));
    r.att  = 14'(clip(at, AttMax));
    r.bank = 15'(clip(bk, BankMax));
    return r;
  endfunction

  // ---------------- checking ----------------
  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      euler_t e;
      if (angles_due.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        e = angles_due.pop_front();
        if ($signed(m_axis_tdata_o[15:0]) != e.head)
          report("heading", $signed(m_axis_tdata_o[15:0]), e.head);
        if ($signed(m_axis_tdata_o[29:16]) != e.att)
          report("attitude", $signed(m_axis_tdata_o[29:16]), e.att);
        if ($signed(m_axis_tdata_o[44:30]) != e.bank)
          report("bank", $signed(m_axis_tdata_o[44:30]), e.bank);
        if (m_axis_tdata_o[47:45] != 3'b000)
          report("pad bits", m_axis_tdata_o[47:45], 0);
        if (m_axis_tuser_o != e.lock)
          report("lock case", m_axis_tuser_o, e.lock);
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    case (idle_mode)
      0:       m_axis_tready_i <= ($urandom_range(99) >= 68);
      1:       m_axis_tready_i <= ($urandom_range(99) >= 13);
      default: m_axis_tready_i <= 1'b1;
    endcase
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= Stall) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  // call at a falling edge; returns at the falling edge after the transaction
  // with tvalid still high, so the next call can follow without a gap
  task automatic send_quat(quat_t q, bit pinned, lock_e lk);
    euler_t e;
    int gap;
    gap = (idle_mode == 0) ? 13 : (idle_mode == 1) ? 68 : 0;
    while ($urandom_range(99) < gap) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata_i  = {q.z, q.y, q.x, q.w};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    e = quat_angles(q);
    if (pinned) begin
      e.lock = lk;
      if (lk != LockNone) begin
        e.att  = (lk == LockNorth) ? 14'(AttMax) : 14'(-AttMax);
        e.bank = '0;
      end
    end
    angles_due = {angles_due, e};
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i = 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (Latency + 6) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [30:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    lock_limit  = v;
  endtask

  function automatic quat_t random_quat();
    quat_t q;
    real a, b, c, d, n;
    int p, sx, sz;
    case ($urandom_range(2))
      0: begin
        q.w = 16'($urandom); q.x = 16'($urandom); q.y = 16'($urandom); q.z = 16'($urandom);
      end
      1: begin
        // unit length with random direction
        a = $itor($signed(16'($urandom)));
        b = $itor($signed(16'($urandom)));
        c = $itor($signed(16'($urandom)));
        d = $itor($signed(16'($urandom)));
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        q.w = 16'($rtoi(a * 32767.0 / n)); q.x = 16'($rtoi(b * 32767.0 / n));
        q.y = 16'($rtoi(c * 32767.0 / n)); q.z = 16'($rtoi(d * 32767.0 / n));
      end
      default: begin
        // close to a pole: all magnitudes near 1/sqrt(2), t sign chosen
        p  = $urandom_range(1) ? 1 : -1;
        sx = $urandom_range(1) ? 1 : -1;
        sz = $urandom_range(1) ? 1 : -1;
        q.x = 16'(sx * (23170 - 200 + $urandom_range(400)));
        q.y = 16'(sx * p * (23170 - 200 + $urandom_range(400)));
        q.z = 16'(sz * (23170 - 200 + $urandom_range(400)));
        q.w = 16'(sz * p * (23170 - 200 + $urandom_range(400)));
      end
    endcase
    return q;
  endfunction

  task automatic random_run(int n);
    repeat (n) send_quat(random_quat(), 1'b0, LockNone);
  endtask

  row_t plan[$];

  initial begin
    plan = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, LockNone},
      '{'{16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 1'b1, LockNone},
      '{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 1'b1, LockNone},
      '{'{16'sd0, 16'sd32767, 16'sd0, 16'sd0}, 1'b1, LockNone},
      '{'{16'sd0, 16'sd0, -16'sd32768, 16'sd0}, 1'b1, LockNone},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767}, 1'b1, LockNone},
      '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b1, LockNorth},
      '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b1, LockNorth},
      '{'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b1, LockSouth},
      '{'{16'sd23170, 16'sd23170, 16'sd23170, 16'sd23170}, 1'b1, LockNorth},
      '{'{-16'sd23170, 16'sd23170, -16'sd23170, 16'sd23170}, 1'b1, LockSouth},
      '{'{16'sd23170, -16'sd23170, 16'sd23170, 16'sd23170}, 1'b1, LockNone},
      '{'{16'sd23170, 16'sd23170, 16'sd23170, -16'sd23170}, 1'b1, LockNone},
      // bank operands both zero
      '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd16384}, 1'b1, LockNone},
      // heading operands both zero
      '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd16384}, 1'b1, LockNone},
      '{'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}, 1'b0, LockNone},
      '{'{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384}, 1'b0, LockNone},
      '{'{16'sd1, -16'sd1, 16'sd1, -16'sd1}, 1'b0, LockNone},
      '{'{-16'sd1, 16'sd21, -16'sd300, 16'sd5000}, 1'b0, LockNone},
      '{'{16'sd28377, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, LockNone},
      '{'{16'sd28377, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, LockNone}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_mode = 0;
    foreach (plan[i]) send_quat(plan[i].q, plan[i].pinned, plan[i].lock);
    random_run(80);
    drain();

    // zero limit: every nonzero t locks
    set_limit(31'd0);
    idle_mode = 1;
    random_run(100);
    drain();

    set_limit(31'd1073741824);
    idle_mode = 2;
    random_run(100);
    drain();

    // widest limit: lock only at the largest t, asin input clamps
    set_limit(31'h7FFFFFFF);
    idle_mode = 0;
    random_run(100);
    drain();

    set_limit(31'd268435456);
    idle_mode = 2;
    random_run(100);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
src/qte_pkg.sv
src/qte_front.sv
src/qte_sqrt.sv
src/qte_cordic.sv
src/qte_scale.sv
src/quat_to_euler.sv
sim/tb_quat_to_euler.sv
